// ===== hdl/dns_tlsa_answer_extractor_defines.svh =====
// ---------------------------------------------------------------------------
// DNS TLSA answer extractor assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef DNS_TLSA_ANSWER_EXTRACTOR_DEFINES_SVH
`define DNS_TLSA_ANSWER_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define DTAE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTAE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dtae_pkg.sv =====
// ---------------------------------------------------------------------------
// dtae_pkg
// Types and codes shared by the DNS TLSA answer extractor modules.
// ---------------------------------------------------------------------------
package dtae_pkg;

    localparam int NAME_STEP_LIMIT_DEF = 128;
    localparam int MAX_LABEL_BYTES_DEF = 63;
    localparam logic [15:0] WANTED_TYPE_RESET = 16'd52;

    // command queue between parser and output stage
    localparam int Q_DEPTH = 4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_SHORT        = 3'd1;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd2;
    localparam logic [2:0] ST_TRUNCATED    = 3'd3;
    localparam logic [2:0] ST_BAD_NAME     = 3'd4;
    localparam logic [2:0] ST_ENDED_EARLY  = 3'd5;

    // one parsed byte's work: an optional record word, then an optional status word
    typedef struct packed {
        logic        rec_valid;
        logic        rec_is_data;
        logic [7:0]  usage;
        logic [7:0]  selector;
        logic [7:0]  mt_or_byte;
        logic [15:0] data_length;
        logic        data_end;
        logic        sta_valid;
        logic [2:0]  status;
    } cmd_t;

endpackage

// ===== hdl/dtae_byte_if.sv =====
// ---------------------------------------------------------------------------
// dtae_byte_if
// Packet byte channel: one byte and a last flag per word.
// ---------------------------------------------------------------------------
interface dtae_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);
endinterface

// ===== hdl/dtae_rec_if.sv =====
// ---------------------------------------------------------------------------
// dtae_rec_if
// Result channel: record headers, data bytes and end status words.
// ---------------------------------------------------------------------------
interface dtae_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  usage;
    logic [7:0]  selector;
    logic [7:0]  match_type;
    logic [15:0] data_length;
    logic [7:0]  data_byte;
    logic        data_end;
    logic [2:0]  status;

    modport source (output valid, output kind, output usage, output selector,
                    output match_type, output data_length, output data_byte,
                    output data_end, output status, input ready);
    modport sink   (input valid, input kind, input usage, input selector,
                    input match_type, input data_length, input data_byte,
                    input data_end, input status, output ready);
endinterface

// ===== hdl/dtae_cfg_if.sv =====
// ---------------------------------------------------------------------------
// dtae_cfg_if
// Configuration write channel for the wanted record type.
// ---------------------------------------------------------------------------
interface dtae_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] wanted_type;

    modport source (output valid, output wanted_type, input ready);
    modport sink   (input valid, input wanted_type, output ready);
endinterface

// ===== hdl/dtae_front.sv =====
// ---------------------------------------------------------------------------
// dtae_front
// Byte parser: walks header, questions and answers, emits at most one command per byte.
// ---------------------------------------------------------------------------
module dtae_front #(
    parameter int NAME_STEP_LIMIT = dtae_pkg::NAME_STEP_LIMIT_DEF,
    parameter int MAX_LABEL_BYTES = dtae_pkg::MAX_LABEL_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    dtae_byte_if.sink         packet,
    input  logic [15:0]       wanted_type,
    input  logic              q_full,
    output logic              push,
    output dtae_pkg::cmd_t    cmd
);

    localparam int SW = $clog2(NAME_STEP_LIMIT + 1);
    localparam int LW = (MAX_LABEL_BYTES > 1) ? $clog2(MAX_LABEL_BYTES + 1) : 1;
    localparam logic [3:0] HDR_LAST = 4'd11;

    typedef enum logic [10:0] {
        PH_HEADER     = 11'b000_0000_0001,
        PH_NAME_LEN   = 11'b000_0000_0010,
        PH_NAME_LABEL = 11'b000_0000_0100,
        PH_NAME_PTR   = 11'b000_0000_1000,
        PH_QFIXED     = 11'b000_0001_0000,
        PH_AFIXED     = 11'b000_0010_0000,
        PH_RHDR       = 11'b000_0100_0000,
        PH_RDATA      = 11'b000_1000_0000,
        PH_RSKIP      = 11'b001_0000_0000,
        PH_DONE       = 11'b010_0000_0000,
        PH_ERROR      = 11'b100_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fpos_reg, fpos_next;
    logic [7:0]  flag_reg, flag_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [LW-1:0] label_reg, label_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] rleft_reg, rleft_next;
    logic [7:0]  usage_reg, usage_next;
    logic [7:0]  sel_reg, sel_next;
    logic [2:0]  estat_reg, estat_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] rd_new;
    logic [15:0] rd_dec;
    logic [15:0] q_dec;
    logic [15:0] a_dec;

    assign packet.ready = !q_full;
    assign accept       = packet.valid && packet.ready;
    assign b            = packet.byte_in;
    assign rd_new       = {rleft_reg[15:8], b};
    assign rd_dec       = rleft_reg - 16'd1;
    assign q_dec        = qleft_reg - 16'd1;
    assign a_dec        = aleft_reg - 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        fpos_next  = fpos_reg;
        flag_next  = flag_reg;
        qleft_next = qleft_reg;
        aleft_next = aleft_reg;
        steps_next = steps_reg;
        label_next = label_reg;
        rtype_next = rtype_reg;
        rleft_next = rleft_reg;
        usage_next = usage_reg;
        sel_next   = sel_reg;
        estat_next = estat_reg;
        cmd        = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (fpos_reg == 4'd2)
                begin
                    flag_next = b;
                end
                else if (fpos_reg == 4'd3)
                begin
                    if (!flag_reg[7] || (b[3:0] != 4'h0))
                        estat_next = dtae_pkg::ST_NOT_RESPONSE;
                    else if (flag_reg[1])
                        estat_next = dtae_pkg::ST_TRUNCATED;
                end
                else if (fpos_reg == 4'd4)
                begin
                    qleft_next = {b, 8'h00};
                end
                else if (fpos_reg == 4'd5)
                begin
                    qleft_next = {qleft_reg[15:8], b};
                end
                else if (fpos_reg == 4'd6)
                begin
                    aleft_next = {b, 8'h00};
                end
                else if (fpos_reg == 4'd7)
                begin
                    aleft_next = {aleft_reg[15:8], b};
                end
                if (fpos_reg >= HDR_LAST)
                begin
                    fpos_next = 4'd0;
                    if (estat_reg != dtae_pkg::ST_OK)
                        phase_next = PH_ERROR;
                    else if ((qleft_reg != 16'd0) || (aleft_reg != 16'd0))
                    begin
                        phase_next = PH_NAME_LEN;
                        steps_next = '0;
                        label_next = '0;
                    end
                    else
                        phase_next = PH_DONE;
                end
                else
                begin
                    fpos_next = fpos_reg + 4'd1;
                end
            end

            PH_NAME_LEN:
            begin
                if (steps_reg >= SW'(NAME_STEP_LIMIT))
                begin
                    estat_next = dtae_pkg::ST_BAD_NAME;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    steps_next = steps_reg + SW'(1);
                    if (b == 8'h00)
                    begin
                        fpos_next  = 4'd0;
                        phase_next = (qleft_reg != 16'd0) ? PH_QFIXED : PH_AFIXED;
                    end
                    else if ((b & 8'hC0) == 8'hC0)
                    begin
                        phase_next = PH_NAME_PTR;
                    end
                    else if (b > 8'(MAX_LABEL_BYTES))
                    begin
                        estat_next = dtae_pkg::ST_BAD_NAME;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        label_next = b[LW-1:0];
                        phase_next = PH_NAME_LABEL;
                    end
                end
            end

            PH_NAME_LABEL:
            begin
                label_next = label_reg - LW'(1);
                if (label_reg == LW'(1))
                    phase_next = PH_NAME_LEN;
            end

            PH_NAME_PTR:
            begin
                fpos_next  = 4'd0;
                phase_next = (qleft_reg != 16'd0) ? PH_QFIXED : PH_AFIXED;
            end

            PH_QFIXED:
            begin
                if (fpos_reg >= 4'd3)
                begin
                    fpos_next  = 4'd0;
                    qleft_next = q_dec;
                    if ((q_dec != 16'd0) || (aleft_reg != 16'd0))
                    begin
                        phase_next = PH_NAME_LEN;
                        steps_next = '0;
                        label_next = '0;
                    end
                    else
                        phase_next = PH_DONE;
                end
                else
                begin
                    fpos_next = fpos_reg + 4'd1;
                end
            end

            PH_AFIXED:
            begin
                if (fpos_reg == 4'd0)
                    rtype_next = {b, 8'h00};
                else if (fpos_reg == 4'd1)
                    rtype_next = {rtype_reg[15:8], b};
                else if (fpos_reg == 4'd8)
                    rleft_next = {b, 8'h00};
                else if (fpos_reg == 4'd9)
                    rleft_next = rd_new;
                if (fpos_reg >= 4'd9)
                begin
                    fpos_next = 4'd0;
                    if (rd_new == 16'd0)
                    begin
                        aleft_next = a_dec;
                        if ((qleft_reg != 16'd0) || (a_dec != 16'd0))
                        begin
                            phase_next = PH_NAME_LEN;
                            steps_next = '0;
                            label_next = '0;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    else if ((rtype_reg == wanted_type) && (rd_new >= 16'd4))
                        phase_next = PH_RHDR;
                    else
                        phase_next = PH_RSKIP;
                end
                else
                begin
                    fpos_next = fpos_reg + 4'd1;
                end
            end

            PH_RHDR:
            begin
                rleft_next = rd_dec;
                if (fpos_reg == 4'd0)
                begin
                    usage_next = b;
                    fpos_next  = 4'd1;
                end
                else if (fpos_reg == 4'd1)
                begin
                    sel_next  = b;
                    fpos_next = 4'd2;
                end
                else
                begin
                    cmd.rec_valid   = 1'b1;
                    cmd.rec_is_data = 1'b0;
                    cmd.usage       = usage_reg;
                    cmd.selector    = sel_reg;
                    cmd.mt_or_byte  = b;
                    cmd.data_length = rd_dec;
                    fpos_next       = 4'd0;
                    phase_next      = PH_RDATA;
                end
            end

            PH_RDATA, PH_RSKIP:
            begin
                rleft_next = rd_dec;
                if (phase_reg == PH_RDATA)
                begin
                    cmd.rec_valid   = 1'b1;
                    cmd.rec_is_data = 1'b1;
                    cmd.mt_or_byte  = b;
                    cmd.data_end    = (rd_dec == 16'd0);
                end
                if (rd_dec == 16'd0)
                begin
                    aleft_next = a_dec;
                    if ((qleft_reg != 16'd0) || (a_dec != 16'd0))
                    begin
                        phase_next = PH_NAME_LEN;
                        steps_next = '0;
                        label_next = '0;
                    end
                    else
                        phase_next = PH_DONE;
                end
            end

            default:
            begin
                // done or error: bytes are dropped until the last one
            end
        endcase

        if (packet.last)
        begin
            cmd.sta_valid = 1'b1;
            if (phase_next == PH_ERROR)
                cmd.status = estat_next;
            else if (phase_next == PH_DONE)
                cmd.status = dtae_pkg::ST_OK;
            else if (phase_next == PH_HEADER)
                cmd.status = dtae_pkg::ST_SHORT;
            else
                cmd.status = dtae_pkg::ST_ENDED_EARLY;
            phase_next = PH_HEADER;
            fpos_next  = 4'd0;
            flag_next  = 8'h00;
            qleft_next = 16'd0;
            aleft_next = 16'd0;
            steps_next = '0;
            label_next = '0;
            rtype_next = 16'd0;
            rleft_next = 16'd0;
            usage_next = 8'h00;
            sel_next   = 8'h00;
            estat_next = dtae_pkg::ST_OK;
        end
    end

    assign push = accept && (cmd.rec_valid || cmd.sta_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fpos_reg  <= 4'd0;
            flag_reg  <= 8'h00;
            qleft_reg <= 16'd0;
            aleft_reg <= 16'd0;
            steps_reg <= '0;
            label_reg <= '0;
            rtype_reg <= 16'd0;
            rleft_reg <= 16'd0;
            usage_reg <= 8'h00;
            sel_reg   <= 8'h00;
            estat_reg <= dtae_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            fpos_reg  <= fpos_next;
            flag_reg  <= flag_next;
            qleft_reg <= qleft_next;
            aleft_reg <= aleft_next;
            steps_reg <= steps_next;
            label_reg <= label_next;
            rtype_reg <= rtype_next;
            rleft_reg <= rleft_next;
            usage_reg <= usage_next;
            sel_reg   <= sel_next;
            estat_reg <= estat_next;
        end
    end

endmodule

// ===== hdl/dtae_queue.sv =====
// ---------------------------------------------------------------------------
// dtae_queue
// Short command FIFO between the parser and the output stage.
// ---------------------------------------------------------------------------
`include "dns_tlsa_answer_extractor_defines.svh"

module dtae_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dtae_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output dtae_pkg::cmd_t    head_cmd,
    output logic              full,
    output logic              nonempty
);

    localparam int PW = $clog2(dtae_pkg::Q_DEPTH);
    localparam int CW = $clog2(dtae_pkg::Q_DEPTH + 1);

    dtae_pkg::cmd_t entry_reg [dtae_pkg::Q_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CW'(dtae_pkg::Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_cmd = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `DTAE_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push, "push into full queue")
    `DTAE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, !nonempty, !pop, "pop from empty queue")
    `DTAE_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CW'(1), "count did not rise on push")
    `DTAE_ASSERT_NXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CW'(1), "count did not fall on pop")

endmodule

// ===== hdl/dtae_back.sv =====
// ---------------------------------------------------------------------------
// dtae_back
// Output stage: turns each command into one or two result words.
// ---------------------------------------------------------------------------
module dtae_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dtae_pkg::cmd_t    head_cmd,
    input  logic              q_nonempty,
    output logic              pop,
    dtae_rec_if.source        records
);

    dtae_pkg::cmd_t hold_reg;
    logic           hold_valid_reg, hold_valid_next;
    logic           rec_pend_reg, rec_pend_next;
    logic           fire;
    logic           cmd_done;

    assign fire     = records.valid && records.ready;
    // the record word goes first; a pending status keeps the command held
    assign cmd_done = fire && !(rec_pend_reg && hold_reg.sta_valid);
    assign pop      = q_nonempty && (!hold_valid_reg || cmd_done);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        rec_pend_next   = rec_pend_reg;
        if (pop)
        begin
            hold_valid_next = 1'b1;
            rec_pend_next   = head_cmd.rec_valid;
        end
        else if (cmd_done)
        begin
            hold_valid_next = 1'b0;
            rec_pend_next   = 1'b0;
        end
        else if (fire)
        begin
            rec_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            hold_reg <= head_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            rec_pend_reg   <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            rec_pend_reg   <= rec_pend_next;
        end
    end

    always_comb
    begin
        records.valid       = hold_valid_reg;
        records.kind        = dtae_pkg::KIND_STATUS;
        records.usage       = 8'h00;
        records.selector    = 8'h00;
        records.match_type  = 8'h00;
        records.data_length = 16'd0;
        records.data_byte   = 8'h00;
        records.data_end    = 1'b0;
        records.status      = dtae_pkg::ST_OK;
        if (rec_pend_reg)
        begin
            if (hold_reg.rec_is_data)
            begin
                records.kind      = dtae_pkg::KIND_DATA;
                records.data_byte = hold_reg.mt_or_byte;
                records.data_end  = hold_reg.data_end;
            end
            else
            begin
                records.kind        = dtae_pkg::KIND_HEADER;
                records.usage       = hold_reg.usage;
                records.selector    = hold_reg.selector;
                records.match_type  = hold_reg.mt_or_byte;
                records.data_length = hold_reg.data_length;
            end
        end
        else
        begin
            records.status = hold_reg.status;
        end
    end

endmodule

// ===== hdl/dns_tlsa_answer_extractor.sv =====
// ---------------------------------------------------------------------------
// dns_tlsa_answer_extractor
// Streams TLSA-style record fields out of a DNS response, one byte a cycle.
// ---------------------------------------------------------------------------
// Accepts one packet byte per cycle while the command queue is not full.
// A last byte with a record word gives two words, one per cycle while ready.
// A four-entry command queue lets parser and output stall independently.
// Reset (rst_n low, async) returns the parser to the packet header, empties
// the queue and sets wanted_type to 52.
module dns_tlsa_answer_extractor #(
    parameter int NAME_STEP_LIMIT = dtae_pkg::NAME_STEP_LIMIT_DEF,
    parameter int MAX_LABEL_BYTES = dtae_pkg::MAX_LABEL_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dtae_byte_if.sink   packet,
    dtae_rec_if.source  records,
    dtae_cfg_if.sink    cfg
);

    logic [15:0]    wanted_type_reg;
    logic [15:0]    wanted_type_next;
    logic           q_full;
    logic           q_nonempty;
    logic           push;
    logic           pop;
    dtae_pkg::cmd_t push_cmd;
    dtae_pkg::cmd_t head_cmd;

    assign cfg.ready        = 1'b1;
    assign wanted_type_next = (cfg.valid && cfg.ready) ? cfg.wanted_type : wanted_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_type_reg <= dtae_pkg::WANTED_TYPE_RESET;
        else
            wanted_type_reg <= wanted_type_next;
    end

    dtae_front #(
        .NAME_STEP_LIMIT (NAME_STEP_LIMIT),
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .packet      (packet),
        .wanted_type (wanted_type_reg),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    dtae_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    dtae_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .q_nonempty (q_nonempty),
        .pop        (pop),
        .records    (records)
    );

endmodule

// ===== tb/dns_answer_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dns_answer_checker
// Watches the byte, record and config channels of the TLSA answer extractor,
// tracks the packet parse on its own and compares every record word with the
// oldest predicted one. Reports failures and the number of words still owed.
// ---------------------------------------------------------------------------
module dns_answer_checker #(
    parameter int NAME_STEP_LIMIT = dtae_pkg::NAME_STEP_LIMIT_DEF,
    parameter int MAX_LABEL_BYTES = dtae_pkg::MAX_LABEL_BYTES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dtae_byte_if packet,
    dtae_rec_if  records,
    dtae_cfg_if  cfg,
    output int   fail_count,
    output int   words_pending
);

    localparam int HDR_LEN = 12;

    typedef enum logic [3:0] {
        P_HDR, P_LEN, P_LABEL, P_PTR, P_QFIX, P_AFIX,
        P_RHDR, P_RDATA, P_RSKIP, P_DONE, P_ERR
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  usage;
        logic [7:0]  selector;
        logic [7:0]  match_type;
        logic [15:0] data_length;
        logic [7:0]  data_byte;
        logic        data_end;
        logic [2:0]  status;
    } rec_word_t;

    rec_word_t    expected_words[$];
    parse_phase_t phase;
    logic [3:0]   pos;
    logic [7:0]   flags_hold;
    logic [15:0]  q_left;
    logic [15:0]  a_left;
    logic [7:0]   steps;
    logic [6:0]   label_left;
    logic [15:0]  rtype;
    logic [15:0]  rdata_left;
    logic [7:0]   usage_hold;
    logic [7:0]   sel_hold;
    logic [2:0]   err_status;
    logic [15:0]  wanted = dtae_pkg::WANTED_TYPE_RESET;
    int           errors = 0;

    function automatic void clear_parse();
        phase      = P_HDR;
        pos        = '0;
        flags_hold = '0;
        q_left     = '0;
        a_left     = '0;
        steps      = '0;
        label_left = '0;
        rtype      = '0;
        rdata_left = '0;
        usage_hold = '0;
        sel_hold   = '0;
        err_status = dtae_pkg::ST_OK;
    endfunction

    function automatic void add_word(logic [1:0] k, logic [7:0] u, logic [7:0] s,
                                     logic [7:0] m, logic [15:0] dl, logic [7:0] db,
                                     logic de, logic [2:0] st);
        rec_word_t w;
        w = '{kind: k, usage: u, selector: s, match_type: m, data_length: dl,
              data_byte: db, data_end: de, status: st};
        expected_words.insert(expected_words.size(), w);
    endfunction

    // start the next question or answer name, or stop once both counts are used up
    function automatic void next_entry();
        if (q_left != 0 || a_left != 0)
        begin
            phase      = P_LEN;
            steps      = '0;
            label_left = '0;
        end
        else
            phase = P_DONE;
    endfunction

    function automatic void name_done();
        pos   = '0;
        phase = (q_left != 0) ? P_QFIX : P_AFIX;
    endfunction

    function automatic void answer_done();
        a_left = a_left - 16'd1;
        next_entry();
    endfunction

    function automatic void track_byte(logic [7:0] b, logic is_last);
        logic [2:0] st;
        case (phase)
            P_HDR:
            begin
                case (pos)
                    4'd2: flags_hold = b;
                    4'd3:
                    begin
                        if (!flags_hold[7] || b[3:0] != 4'd0)
                            err_status = dtae_pkg::ST_NOT_RESPONSE;
                        else if (flags_hold[1])
                            err_status = dtae_pkg::ST_TRUNCATED;
                    end
                    4'd4: q_left = {b, 8'h00};
                    4'd5: q_left[7:0] = b;
                    4'd6: a_left = {b, 8'h00};
                    4'd7: a_left[7:0] = b;
                    default: ;
                endcase
                if (pos == HDR_LEN - 1)
                begin
                    pos = '0;
                    if (err_status != dtae_pkg::ST_OK)
                        phase = P_ERR;
                    else
                        next_entry();
                end
                else
                    pos = pos + 4'd1;
            end
            P_LEN:
            begin
                if (steps >= NAME_STEP_LIMIT)
                begin
                    err_status = dtae_pkg::ST_BAD_NAME;
                    phase      = P_ERR;
                end
                else
                begin
                    steps = steps + 8'd1;
                    if (b == 8'd0)
                        name_done();
                    else if (b[7:6] == 2'b11)
                        phase = P_PTR;
                    else if (b > MAX_LABEL_BYTES)
                    begin
                        err_status = dtae_pkg::ST_BAD_NAME;
                        phase      = P_ERR;
                    end
                    else
                    begin
                        label_left = b[6:0];
                        phase      = P_LABEL;
                    end
                end
            end
            P_LABEL:
            begin
                label_left = label_left - 7'd1;
                if (label_left == 0)
                    phase = P_LEN;
            end
            P_PTR:
                name_done();
            P_QFIX:
            begin
                if (pos >= 4'd3)
                begin
                    pos    = '0;
                    q_left = q_left - 16'd1;
                    next_entry();
                end
                else
                    pos = pos + 4'd1;
            end
            P_AFIX:
            begin
                case (pos)
                    4'd0: rtype = {b, 8'h00};
                    4'd1: rtype[7:0] = b;
                    4'd8: rdata_left = {b, 8'h00};
                    4'd9: rdata_left[7:0] = b;
                    default: ;
                endcase
                if (pos >= 4'd9)
                begin
                    pos = '0;
                    if (rdata_left == 0)
                        answer_done();
                    else if (rtype == wanted && rdata_left >= 16'd4)
                        phase = P_RHDR;
                    else
                        phase = P_RSKIP;
                end
                else
                    pos = pos + 4'd1;
            end
            P_RHDR:
            begin
                rdata_left = rdata_left - 16'd1;
                if (pos == 4'd0)
                begin
                    usage_hold = b;
                    pos        = 4'd1;
                end
                else if (pos == 4'd1)
                begin
                    sel_hold = b;
                    pos      = 4'd2;
                end
                else
                begin
                    add_word(dtae_pkg::KIND_HEADER, usage_hold, sel_hold, b, rdata_left,
                             8'd0, 1'b0, dtae_pkg::ST_OK);
                    pos   = '0;
                    phase = P_RDATA;
                end
            end
            P_RDATA:
            begin
                rdata_left = rdata_left - 16'd1;
                add_word(dtae_pkg::KIND_DATA, 8'd0, 8'd0, 8'd0, 16'd0, b, rdata_left == 0,
                         dtae_pkg::ST_OK);
                if (rdata_left == 0)
                    answer_done();
            end
            P_RSKIP:
            begin
                rdata_left = rdata_left - 16'd1;
                if (rdata_left == 0)
                    answer_done();
            end
            default: ;
        endcase

        if (is_last)
        begin
            if (phase == P_ERR)
                st = err_status;
            else if (phase == P_DONE)
                st = dtae_pkg::ST_OK;
            else if (phase == P_HDR)
                st = dtae_pkg::ST_SHORT;
            else
                st = dtae_pkg::ST_ENDED_EARLY;
            add_word(dtae_pkg::KIND_STATUS, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, st);
            clear_parse();
        end
    endfunction

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function automatic void check_word();
        rec_word_t w;
        if (expected_words.size() == 0)
        begin
            $error("record word with nothing predicted: kind %0d", records.kind);
            errors++;
            return;
        end
        w = expected_words.pop_front();
        compare_field("kind", w.kind, records.kind);
        compare_field("usage", w.usage, records.usage);
        compare_field("selector", w.selector, records.selector);
        compare_field("match_type", w.match_type, records.match_type);
        compare_field("data_length", w.data_length, records.data_length);
        compare_field("data_byte", w.data_byte, records.data_byte);
        compare_field("data_end", w.data_end, records.data_end);
        compare_field("status", w.status, records.status);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            wanted = dtae_pkg::WANTED_TYPE_RESET;
            expected_words.delete();
            fail_count    <= errors;
            words_pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                wanted = cfg.wanted_type;
            // predict before comparing so a same-cycle word still finds its entry
            if (packet.valid && packet.ready)
                track_byte(packet.byte_in, packet.last);
            if (records.valid && records.ready)
                check_word();
            fail_count    <= errors;
            words_pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/tb_dns_tlsa_answer_extractor.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dns_tlsa_answer_extractor
// Feeds DNS response packets through the TLSA answer extractor: a directed
// set of header, name and record corner cases, then random packets, mostly
// well formed, under several wanted types. Both sides idle at random; the
// checker beside the block predicts and compares every record word.
// ---------------------------------------------------------------------------
module tb_dns_tlsa_answer_extractor;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          ITEM_TARGET   = 1250;
    localparam logic [15:0] TYPE_TLSA     = 16'd52;

    logic        clk;
    logic        rst_n;
    int          cycle_count = 0;
    int          fail_count;
    int          words_pending;
    int          bytes_sent = 0;
    bit          no_gaps = 1'b0;
    int          ready_hold = 0;
    int          ready_pick;
    logic [15:0] wanted = TYPE_TLSA;
    logic [7:0]  msg_bytes[$];

    dtae_byte_if packet();
    dtae_rec_if  records();
    dtae_cfg_if  cfg();

    dns_tlsa_answer_extractor u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .packet  (packet),
        .records (records),
        .cfg     (cfg)
    );

    dns_answer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .packet        (packet),
        .records       (records),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** dns_tlsa_answer_extractor: FAILED **");
            $finish;
        end
    end

    // record sink: short stalls, ready runs, now and then a long stall
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_pick = $urandom_range(99);
            if (ready_pick < 50)
            begin
                records.ready <= 1'b1;
                ready_hold    <= $urandom_range(19);
            end
            else if (ready_pick < 85)
            begin
                records.ready <= 1'b0;
                ready_hold    <= $urandom_range(2);
            end
            else if (ready_pick < 93)
            begin
                records.ready <= 1'b1;
                ready_hold    <= $urandom_range(200, 50);
            end
            else if (ready_pick < 98)
            begin
                records.ready <= 1'b0;
                ready_hold    <= $urandom_range(9, 3);
            end
            else
            begin
                records.ready <= 1'b0;
                ready_hold    <= $urandom_range(40, 20);
            end
        end
    end

    function automatic int pick_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(3, 1);
        else if (p < 98)
            return $urandom_range(8, 4);
        return $urandom_range(30, 15);
    endfunction

    function automatic logic [15:0] pick_rdlen();
        int p;
        p = $urandom_range(99);
        if (p < 5)
            return 16'd0;
        else if (p < 15)
            return 16'($urandom_range(3, 1));
        else if (p < 90)
            return 16'($urandom_range(16, 4));
        return 16'($urandom_range(60, 17));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        packet.valid   <= 1'b1;
        packet.byte_in <= b;
        packet.last    <= is_last;
        do
            @(posedge clk);
        while (!packet.ready);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            packet.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sends the first n bytes of the built packet, last flag on the n-th
    task automatic send_packet(input int n);
        no_gaps = ($urandom_range(99) < 25);
        for (int i = 0; i < n; i++)
            send_byte(msg_bytes[i], i == n - 1);
    endtask

    task automatic send_all();
        send_packet(msg_bytes.size());
    endtask

    // called right after a handshake edge: drop valid, then wait out every owed word
    task automatic drain_records();
        packet.valid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wanted(input logic [15:0] value);
        drain_records();
        cfg.valid       <= 1'b1;
        cfg.wanted_type <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        wanted = value;
    endtask

    task automatic add_byte(input logic [7:0] v);
        msg_bytes.insert(msg_bytes.size(), v);
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom));
    endtask

    task automatic put_header(input logic [7:0] f2, input logic [7:0] f3,
                              input logic [15:0] qd, input logic [15:0] an);
        put_random(2);
        add_byte(f2);
        add_byte(f3);
        add_byte(qd[15:8]);
        add_byte(qd[7:0]);
        add_byte(an[15:8]);
        add_byte(an[7:0]);
        put_random(4);
    endtask

    task automatic put_labels(input int count, input int len);
        for (int i = 0; i < count; i++)
        begin
            add_byte(8'(len));
            put_random(len);
        end
    endtask

    task automatic put_name(input bit ptr_end);
        int n;
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
            put_labels(1, ($urandom_range(99) < 5) ? 63 : $urandom_range(10, 1));
        if (ptr_end)
        begin
            add_byte(8'hC0 | 8'($urandom_range(63)));
            put_random(1);
        end
        else
            add_byte(8'h00);
    endtask

    task automatic put_answer(input logic [15:0] rtype, input logic [15:0] rdlen,
                              input int ndata);
        put_name(1'($urandom));
        add_byte(rtype[15:8]);
        add_byte(rtype[7:0]);
        put_random(6);
        add_byte(rdlen[15:8]);
        add_byte(rdlen[7:0]);
        put_random(ndata);
    endtask

    task automatic run_directed();
        logic [7:0] bad_lens[3];
        bad_lens = '{8'h40, 8'hBF, 8'd64};

        // lone byte, header one byte short, bare header
        msg_bytes = {8'hFF};
        send_all();
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd0, 16'd0);
        send_packet(11);
        send_all();

        // not a response; nonzero rcode beats truncation; truncation alone
        msg_bytes.delete();
        put_header(8'h00, 8'h00, 16'd1, 16'd1);
        put_random(5);
        send_all();
        msg_bytes.delete();
        put_header(8'hFF, 8'hFF, 16'd0, 16'd0);
        send_all();
        msg_bytes.delete();
        put_header(8'h82, 8'h00, 16'hFFFF, 16'hFFFF);
        put_random(3);
        send_all();

        // full packet: long label, names that may end in a pointer, short, foreign and empty rdata, trailer
        msg_bytes.delete();
        put_header(8'h81, 8'hF0, 16'd1, 16'd5);
        put_labels(1, 63);
        put_labels(2, 1);
        add_byte(8'h00);
        put_random(4);
        put_answer(TYPE_TLSA, 16'd4, 4);
        put_answer(TYPE_TLSA, 16'd3, 3);
        put_answer(16'd1, 16'd5, 5);
        put_answer(TYPE_TLSA, 16'd0, 0);
        put_answer(TYPE_TLSA, 16'd6, 6);
        put_random(3);
        send_all();

        // last data byte on the packet's last byte
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd0, 16'd1);
        put_answer(TYPE_TLSA, 16'd5, 5);
        send_all();

        // record header on the last byte, maximum rdata length
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd0, 16'd1);
        put_answer(TYPE_TLSA, 16'hFFFF, 3);
        send_all();

        // bad length bytes: top bits 01, top bits 10, one past the label limit
        foreach (bad_lens[i])
        begin
            msg_bytes.delete();
            put_header(8'h80, 8'h00, 16'd1, 16'd0);
            add_byte(bad_lens[i]);
            put_random(3);
            send_all();
        end

        // name step limit: exactly at the limit, then one step over
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd1, 16'd0);
        put_labels(127, 1);
        add_byte(8'h00);
        put_random(4);
        send_all();
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd1, 16'd0);
        put_labels(128, 1);
        add_byte(8'h00);
        put_random(4);
        send_all();

        // ended inside a label and inside the question's fixed bytes
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd1, 16'd0);
        put_labels(1, 5);
        send_packet(15);
        msg_bytes.delete();
        put_header(8'h80, 8'h00, 16'd1, 16'd0);
        add_byte(8'h00);
        put_random(4);
        send_packet(15);
    endtask

    task automatic random_packet();
        int          p;
        int          n;
        int          qd;
        int          an;
        logic [15:0] rdlen;
        logic [7:0]  f2;
        logic [7:0]  f3;
        msg_bytes.delete();
        p = $urandom_range(99);
        if (p < 75)
        begin
            qd = $urandom_range(2);
            an = $urandom_range(4);
            put_header(8'h80 | (8'($urandom) & 8'h7D), 8'($urandom) & 8'hF0,
                       16'(qd), 16'(an));
            for (int i = 0; i < qd; i++)
            begin
                put_name(1'($urandom));
                put_random(4);
            end
            for (int i = 0; i < an; i++)
            begin
                rdlen = pick_rdlen();
                put_answer(($urandom_range(99) < 70) ? wanted : 16'($urandom), rdlen, rdlen);
            end
            if ($urandom_range(99) < 25)
                put_random($urandom_range(6, 1));
        end
        else if (p < 85)
        begin
            case ($urandom_range(2))
                0:
                begin
                    f2 = 8'($urandom) & 8'h7F;
                    f3 = 8'($urandom);
                end
                1:
                begin
                    f2 = 8'h80 | 8'($urandom);
                    f3 = 8'($urandom) | 8'h01;
                end
                default:
                begin
                    f2 = 8'h82 | (8'($urandom) & 8'h7D);
                    f3 = 8'($urandom) & 8'hF0;
                end
            endcase
            put_header(f2, f3, 16'($urandom), 16'($urandom));
            put_random($urandom_range(20));
        end
        else if (p < 93)
        begin
            put_header(8'h80, 8'h00, 16'd1, 16'($urandom_range(2)));
            put_labels($urandom_range(2), $urandom_range(8, 1));
            add_byte(8'($urandom_range(191, 64)));
            put_random($urandom_range(10));
        end
        else
            put_random($urandom_range(40, 1));

        n = msg_bytes.size();
        if ($urandom_range(99) < 15 && n > 1)
            n = $urandom_range(n - 1, 1);
        send_packet(n);
    endtask

    initial
    begin
        logic [15:0] phase_types[4];
        int          target;
        rst_n           = 1'b0;
        packet.valid    = 1'b0;
        packet.byte_in  = 8'd0;
        packet.last     = 1'b0;
        cfg.valid       = 1'b0;
        cfg.wanted_type = 16'd0;
        records.ready   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_wanted(TYPE_TLSA);
        run_directed();

        // the rest of the byte budget is split over four wanted types
        phase_types = '{16'h0000, 16'hFFFF, 16'($urandom), TYPE_TLSA};
        foreach (phase_types[k])
        begin
            write_wanted(phase_types[k]);
            target = bytes_sent + (ITEM_TARGET - bytes_sent) / (4 - k);
            while (bytes_sent < target)
            begin
                if ($urandom_range(99) < 3)
                    drain_records();
                random_packet();
            end
        end

        drain_records();
        if (fail_count == 0 && words_pending == 0)
            $display("** dns_tlsa_answer_extractor: PASSED **");
        else
            $display("** dns_tlsa_answer_extractor: FAILED **");
        $finish;
    end

endmodule
